@@ src/bah_pkg.sv @@
// ----------------------------------------------------------------------------
// bah_pkg
// Types and fixed widths shared by the bucketed average history block.
// ----------------------------------------------------------------------------
package bah_pkg;

   localparam int BUCKET_W = 32;
   localparam int PH_W     = 11;
   localparam int MV_W     = 12;
   localparam int TEMP_W   = 12;
   localparam int AGE_W    = 8;
   localparam int AVG_W    = 12;

   localparam logic OP_SAMPLE  = 1'b0;
   localparam logic OP_READ    = 1'b1;
   localparam logic KIND_CLOSE = 1'b0;
   localparam logic KIND_READ  = 1'b1;

   typedef struct packed {
      logic                      opcode;
      logic [BUCKET_W-1:0]       bucket_number;
      logic                      ph_present;
      logic [PH_W-1:0]           ph_hundredths;
      logic                      orp_present;
      logic signed [MV_W-1:0]    orp_millivolts;
      logic                      temp_present;
      logic signed [TEMP_W-1:0]  temp_tenths;
      logic [AGE_W-1:0]          age;
   } req_type;

   typedef struct packed {
      logic                      kind;
      logic                      slot_filled;
      logic                      ph_avg_present;
      logic [PH_W-1:0]           ph_avg;
      logic                      orp_avg_present;
      logic signed [MV_W-1:0]    orp_avg;
      logic                      temp_avg_present;
      logic signed [TEMP_W-1:0]  temp_avg;
   } rsp_type;

   // one ring slot
   typedef struct packed {
      logic                      ph_ok;
      logic [PH_W-1:0]           ph;
      logic                      orp_ok;
      logic signed [MV_W-1:0]    orp;
      logic                      temp_ok;
      logic signed [TEMP_W-1:0]  temp;
   } record_type;

endpackage

@@ src/bah_div.sv @@
// ----------------------------------------------------------------------------
// bah_div
// Serial restoring divider, one quotient bit per cycle, with a final step
// that rounds to nearest with ties to even and restores the sign.
// ----------------------------------------------------------------------------
module bah_div import bah_pkg::*; #(
   parameter int SUMW = 23,
   parameter int CNTW = 11
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [SUMW-1:0]  dividend,
   input  logic [CNTW-1:0]         divisor,
   output logic                    done,
   output logic signed [AVG_W-1:0] quotient
);

   localparam int SW = $clog2(SUMW);

   logic                    busy_ff, busy_in;
   logic                    fin_ff, fin_in;
   logic                    done_ff, done_in;
   logic                    neg_ff, neg_in;
   logic [SW-1:0]           step_ff, step_in;
   logic [CNTW-1:0]         rem_ff, rem_in;
   logic [CNTW-1:0]         den_ff, den_in;
   logic [SUMW-1:0]         quo_ff, quo_in;
   logic signed [AVG_W-1:0] res_ff, res_in;

   logic [CNTW:0]           rem_sh;
   logic [CNTW:0]           rem_diff;
   logic [CNTW:0]           rem_dbl;
   logic                    rnd_up;
   logic [SUMW-1:0]         quo_rnd;
   logic [SUMW-1:0]         quo_sgn;

   always_comb begin
      busy_in  = busy_ff;
      fin_in   = fin_ff;
      done_in  = 1'b0;
      neg_in   = neg_ff;
      step_in  = step_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      quo_in   = quo_ff;
      res_in   = res_ff;

      rem_sh   = {rem_ff, quo_ff[SUMW-1]};
      rem_diff = rem_sh - {1'b0, den_ff};
      rem_dbl  = {rem_ff, 1'b0};
      rnd_up   = (rem_dbl > {1'b0, den_ff}) || ((rem_dbl == {1'b0, den_ff}) && quo_ff[0]);
      quo_rnd  = quo_ff + SUMW'(rnd_up);
      quo_sgn  = neg_ff ? (~quo_rnd + 1'b1) : quo_rnd;

      if (start) begin
         neg_in  = dividend[SUMW-1];
         quo_in  = dividend[SUMW-1] ? (~$unsigned(dividend) + 1'b1) : $unsigned(dividend);
         rem_in  = '0;
         den_in  = divisor;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[SUMW-2:0], ~rem_diff[CNTW]};
         rem_in = rem_diff[CNTW] ? rem_sh[CNTW-1:0] : rem_diff[CNTW-1:0];
         if (step_ff == SW'(SUMW-1)) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end else begin
            step_in = step_ff + 1'b1;
         end
      end else if (fin_ff) begin
         fin_in  = 1'b0;
         done_in = 1'b1;
         res_in  = quo_sgn[AVG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff  <= neg_in;
      step_ff <= step_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quo_ff  <= quo_in;
      res_ff  <= res_in;
   end

   assign done     = done_ff;
   assign quotient = res_ff;

endmodule

@@ src/bah_ring.sv @@
// ----------------------------------------------------------------------------
// bah_ring
// Ring of closed-bucket records: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module bah_ring import bah_pkg::*; #(
   parameter int SLOTS = 256,
   parameter int IDXW  = 8
) (
   input  logic            clock,
   input  logic            wr_en,
   input  logic [IDXW-1:0] wr_addr,
   input  record_type      wr_data,
   input  logic            rd_en,
   input  logic [IDXW-1:0] rd_addr,
   output record_type      rd_data
);

   record_type mem [SLOTS];
   record_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/bucketed_average_history_core.sv @@
// ----------------------------------------------------------------------------
// bucketed_average_history_core
// Accumulates pH, ORP and temperature samples per time bucket; on a bucket
// change the averages are written into a ring of RING_SLOTS records and
// returned, and read transfers fetch a record by age.
// ----------------------------------------------------------------------------
// Handling: one item at a time. A sample in the open bucket (or the first
// sample) is only accumulated. A read passes through ring read, result staging
// and output register. A sample that closes a bucket waits for the three
// averages, which come from three serial dividers running side by side, each
// producing one quotient bit per cycle over the CNTW + 12 bit sum, plus a
// rounding step. The ring needs no clearing after reset; a fill count decides
// which slots hold records.
// ----------------------------------------------------------------------------
module bucketed_average_history_core import bah_pkg::*; #(
   parameter int RING_SLOTS  = 256,
   parameter int MAX_SAMPLES = 1024
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int IDXW  = $clog2(RING_SLOTS);
   localparam int FILLW = $clog2(RING_SLOTS + 1);
   localparam int CNTW  = $clog2(MAX_SAMPLES + 1);
   localparam int SUMW  = CNTW + 12;
   localparam int AW    = ((IDXW > AGE_W) ? IDXW : AGE_W) + 1;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_READ = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   state_type              state_ff, state_in;
   logic                   started_ff, started_in;
   logic [BUCKET_W-1:0]    open_bucket_ff, open_bucket_in;
   logic signed [SUMW-1:0] ph_sum_ff, ph_sum_in;
   logic signed [SUMW-1:0] orp_sum_ff, orp_sum_in;
   logic signed [SUMW-1:0] temp_sum_ff, temp_sum_in;
   logic [CNTW-1:0]        ph_cnt_ff, ph_cnt_in;
   logic [CNTW-1:0]        orp_cnt_ff, orp_cnt_in;
   logic [CNTW-1:0]        temp_cnt_ff, temp_cnt_in;
   logic [IDXW-1:0]        newest_ff, newest_in;
   logic [FILLW-1:0]       filled_ff, filled_in;
   logic                   hit_ff, hit_in;
   req_type                smp_ff, smp_in;
   rsp_type                res_ff, res_in;
   rsp_type                rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic                   accept;
   logic                   out_free;
   logic                   acc_en;
   logic                   acc_clr;
   req_type                smp;
   logic signed [SUMW-1:0] ph_base, orp_base, temp_base;
   logic [CNTW-1:0]        ph_cbase, orp_cbase, temp_cbase;

   logic [AW-1:0]          age_ext;
   logic [AW-1:0]          newest_ext;
   logic [AW-1:0]          idx_diff;
   logic [AW-1:0]          idx_wrap;
   logic                   rd_hit;
   logic [IDXW-1:0]        rd_addr;
   logic [IDXW-1:0]        next_slot;

   logic                   div_start;
   logic                   ph_done, orp_done, temp_done;
   logic signed [AVG_W-1:0] ph_q, orp_q, temp_q;
   record_type             close_rec;
   record_type             rd_rec;
   logic                   wr_en;
   logic                   rd_en;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // ring index of a requested age
   assign age_ext    = AW'(req_data.age);
   assign newest_ext = AW'(newest_ff);
   assign idx_diff   = newest_ext - age_ext;
   assign idx_wrap   = idx_diff + AW'(RING_SLOTS);
   assign rd_hit     = age_ext < AW'(filled_ff);
   assign rd_addr    = (newest_ext >= age_ext) ? idx_diff[IDXW-1:0] : idx_wrap[IDXW-1:0];
   assign next_slot  = (newest_ff == IDXW'(RING_SLOTS - 1)) ? '0 : newest_ff + 1'b1;

   always_comb begin
      close_rec.ph_ok   = (ph_cnt_ff != '0);
      close_rec.ph      = close_rec.ph_ok ? ph_q[PH_W-1:0] : '0;
      close_rec.orp_ok  = (orp_cnt_ff != '0);
      close_rec.orp     = close_rec.orp_ok ? orp_q[MV_W-1:0] : '0;
      close_rec.temp_ok = (temp_cnt_ff != '0);
      close_rec.temp    = close_rec.temp_ok ? temp_q[TEMP_W-1:0] : '0;
   end

   always_comb begin
      state_in       = state_ff;
      started_in     = started_ff;
      open_bucket_in = open_bucket_ff;
      ph_sum_in      = ph_sum_ff;
      orp_sum_in     = orp_sum_ff;
      temp_sum_in    = temp_sum_ff;
      ph_cnt_in      = ph_cnt_ff;
      orp_cnt_in     = orp_cnt_ff;
      temp_cnt_in    = temp_cnt_ff;
      newest_in      = newest_ff;
      filled_in      = filled_ff;
      hit_in         = hit_ff;
      smp_in         = smp_ff;
      res_in         = res_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff;
      acc_en         = 1'b0;
      acc_clr        = 1'b0;
      smp            = req_data;
      div_start      = 1'b0;
      wr_en          = 1'b0;
      rd_en          = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.opcode == OP_READ) begin
                  rd_en    = 1'b1;
                  hit_in   = rd_hit;
                  state_in = ST_READ;
               end else if (!started_ff) begin
                  started_in     = 1'b1;
                  open_bucket_in = req_data.bucket_number;
                  acc_en         = 1'b1;
               end else if (req_data.bucket_number != open_bucket_ff) begin
                  div_start = 1'b1;
                  smp_in    = req_data;
                  state_in  = ST_DIV;
               end else begin
                  acc_en = 1'b1;
               end
            end
         end
         ST_READ: begin
            res_in.kind             = KIND_READ;
            res_in.slot_filled      = hit_ff;
            res_in.ph_avg_present   = hit_ff && rd_rec.ph_ok;
            res_in.ph_avg           = hit_ff ? rd_rec.ph : '0;
            res_in.orp_avg_present  = hit_ff && rd_rec.orp_ok;
            res_in.orp_avg          = hit_ff ? rd_rec.orp : '0;
            res_in.temp_avg_present = hit_ff && rd_rec.temp_ok;
            res_in.temp_avg         = hit_ff ? rd_rec.temp : '0;
            state_in                = ST_EMIT;
         end
         ST_DIV: begin
            if (ph_done) begin
               wr_en          = 1'b1;
               newest_in      = next_slot;
               if (filled_ff != FILLW'(RING_SLOTS)) begin
                  filled_in = filled_ff + 1'b1;
               end
               res_in.kind             = KIND_CLOSE;
               res_in.slot_filled      = 1'b1;
               res_in.ph_avg_present   = close_rec.ph_ok;
               res_in.ph_avg           = close_rec.ph;
               res_in.orp_avg_present  = close_rec.orp_ok;
               res_in.orp_avg          = close_rec.orp;
               res_in.temp_avg_present = close_rec.temp_ok;
               res_in.temp_avg         = close_rec.temp;
               open_bucket_in          = smp_ff.bucket_number;
               acc_en                  = 1'b1;
               acc_clr                 = 1'b1;
               smp                     = smp_ff;
               state_in                = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // accumulate into the open bucket, from zero right after a close
      ph_base    = acc_clr ? '0 : ph_sum_ff;
      orp_base   = acc_clr ? '0 : orp_sum_ff;
      temp_base  = acc_clr ? '0 : temp_sum_ff;
      ph_cbase   = acc_clr ? '0 : ph_cnt_ff;
      orp_cbase  = acc_clr ? '0 : orp_cnt_ff;
      temp_cbase = acc_clr ? '0 : temp_cnt_ff;
      if (acc_en) begin
         ph_sum_in   = ph_base;
         ph_cnt_in   = ph_cbase;
         orp_sum_in  = orp_base;
         orp_cnt_in  = orp_cbase;
         temp_sum_in = temp_base;
         temp_cnt_in = temp_cbase;
         if (smp.ph_present && (ph_cbase < CNTW'(MAX_SAMPLES))) begin
            ph_sum_in = ph_base + {{(SUMW-PH_W){1'b0}}, smp.ph_hundredths};
            ph_cnt_in = ph_cbase + 1'b1;
         end
         if (smp.orp_present && (orp_cbase < CNTW'(MAX_SAMPLES))) begin
            orp_sum_in = orp_base +
               {{(SUMW-MV_W){smp.orp_millivolts[MV_W-1]}}, smp.orp_millivolts};
            orp_cnt_in = orp_cbase + 1'b1;
         end
         if (smp.temp_present && (temp_cbase < CNTW'(MAX_SAMPLES))) begin
            temp_sum_in = temp_base +
               {{(SUMW-TEMP_W){smp.temp_tenths[TEMP_W-1]}}, smp.temp_tenths};
            temp_cnt_in = temp_cbase + 1'b1;
         end
      end

      // output register
      if ((state_ff == ST_EMIT) && out_free) begin
         rsp_in       = res_ff;
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         started_ff     <= 1'b0;
         open_bucket_ff <= '0;
         ph_sum_ff      <= '0;
         orp_sum_ff     <= '0;
         temp_sum_ff    <= '0;
         ph_cnt_ff      <= '0;
         orp_cnt_ff     <= '0;
         temp_cnt_ff    <= '0;
         newest_ff      <= '0;
         filled_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         started_ff     <= started_in;
         open_bucket_ff <= open_bucket_in;
         ph_sum_ff      <= ph_sum_in;
         orp_sum_ff     <= orp_sum_in;
         temp_sum_ff    <= temp_sum_in;
         ph_cnt_ff      <= ph_cnt_in;
         orp_cnt_ff     <= orp_cnt_in;
         temp_cnt_ff    <= temp_cnt_in;
         newest_ff      <= newest_in;
         filled_ff      <= filled_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_ff <= hit_in;
      smp_ff <= smp_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
   end

   bah_div #(.SUMW(SUMW), .CNTW(CNTW)) u_ph_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (ph_sum_ff),
      .divisor  (ph_cnt_ff),
      .done     (ph_done),
      .quotient (ph_q)
   );

   bah_div #(.SUMW(SUMW), .CNTW(CNTW)) u_orp_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (orp_sum_ff),
      .divisor  (orp_cnt_ff),
      .done     (orp_done),
      .quotient (orp_q)
   );

   bah_div #(.SUMW(SUMW), .CNTW(CNTW)) u_temp_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (temp_sum_ff),
      .divisor  (temp_cnt_ff),
      .done     (temp_done),
      .quotient (temp_q)
   );

   bah_ring #(.SLOTS(RING_SLOTS), .IDXW(IDXW)) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (next_slot),
      .wr_data (close_rec),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_rec)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_filled_bound: assert property (@(posedge clock) disable iff (reset)
      filled_ff <= FILLW'(RING_SLOTS))
      else $error("filled slot count above ring size");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (ph_cnt_ff <= CNTW'(MAX_SAMPLES)) && (orp_cnt_ff <= CNTW'(MAX_SAMPLES)) &&
      (temp_cnt_ff <= CNTW'(MAX_SAMPLES)))
      else $error("sample count above limit");

   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      (ph_done == orp_done) && (ph_done == temp_done))
      else $error("dividers out of step");

   a_empty_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.kind == KIND_READ) && !rsp_ff.slot_filled |->
      !rsp_ff.ph_avg_present && !rsp_ff.orp_avg_present && !rsp_ff.temp_avg_present &&
      (rsp_ff.ph_avg == '0) && (rsp_ff.orp_avg == '0) && (rsp_ff.temp_avg == '0))
      else $error("read beyond filled slots returned data");

   a_close_advances: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> (newest_ff != $past(newest_ff)) && (filled_ff != '0))
      else $error("bucket close did not advance ring");
`endif

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for bucketed_average_history_core. Sample and read
// transfers are driven with random idling on both channels; an in-bench
// model of the bucket sums, rounding and history ring predicts every closed
// bucket and every read answer, and each result is checked field by field.
// ----------------------------------------------------------------------------
module tb_top;
   import bah_pkg::*;

   localparam int          RING_SLOTS   = 256;
   localparam int          MAX_SAMPLES  = 1024;
   localparam int          HOLD_CYCLES  = 300;
   localparam int          DRAIN_CYCLES = 64;
   localparam int unsigned CYCLE_LIMIT  = 600000;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   int hold_orders  = 0;
   int hold_taken   = 0;
   int hold_left    = 0;
   int mismatches   = 0;
   int unsigned cycle_count = 0;

   // history model
   logic        hist_started     = 1'b0;
   logic [31:0] hist_open_bucket = '0;
   longint      ph_total = 0, orp_total = 0, temp_total = 0;
   longint      ph_n = 0, orp_n = 0, temp_n = 0;
   int          hist_newest = 0;
   int          hist_filled = 0;
   record_type  hist_ring [RING_SLOTS];
   rsp_type     expected_q [$];

   bucketed_average_history_core #(
      .RING_SLOTS  (RING_SLOTS),
      .MAX_SAMPLES (MAX_SAMPLES)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("** bucketed_average_history_core: FAILED **");
         $finish;
      end
   end

   // ---------------------------------------------------------------- model

   function automatic logic [AVG_W-1:0] average_even(input longint total,
                                                     input longint count);
      longint mag, quo, rem;
      mag = (total < 0) ? -total : total;
      quo = mag / count;
      rem = mag % count;
      if (2 * rem > count || (2 * rem == count && quo[0]))
         quo++;
      if (total < 0)
         quo = -quo;
      return quo[AVG_W-1:0];
   endfunction

   function automatic rsp_type record_to_rsp(input logic kind, input logic filled,
                                             input record_type rec);
      rsp_type res;
      res                  = '0;
      res.kind             = kind;
      res.slot_filled      = filled;
      res.ph_avg_present   = rec.ph_ok;
      res.ph_avg           = rec.ph;
      res.orp_avg_present  = rec.orp_ok;
      res.orp_avg          = rec.orp;
      res.temp_avg_present = rec.temp_ok;
      res.temp_avg         = rec.temp;
      return res;
   endfunction

   function automatic rsp_type close_open_bucket();
      record_type       rec;
      logic [AVG_W-1:0] avg;
      rec = '0;
      if (ph_n != 0) begin
         avg        = average_even(ph_total, ph_n);
         rec.ph_ok  = 1'b1;
         rec.ph     = avg[PH_W-1:0];
      end
      if (orp_n != 0) begin
         avg        = average_even(orp_total, orp_n);
         rec.orp_ok = 1'b1;
         rec.orp    = avg[MV_W-1:0];
      end
      if (temp_n != 0) begin
         avg         = average_even(temp_total, temp_n);
         rec.temp_ok = 1'b1;
         rec.temp    = avg[TEMP_W-1:0];
      end
      hist_newest = (hist_newest + 1) % RING_SLOTS;
      if (hist_filled < RING_SLOTS)
         hist_filled++;
      hist_ring[hist_newest] = rec;
      ph_total = 0;
      orp_total = 0;
      temp_total = 0;
      ph_n = 0;
      orp_n = 0;
      temp_n = 0;
      return record_to_rsp(KIND_CLOSE, 1'b1, rec);
   endfunction

   function automatic void predict_item(input req_type item);
      int slot;
      if (item.opcode == OP_READ) begin
         if (int'(item.age) < hist_filled) begin
            slot = (hist_newest + RING_SLOTS - int'(item.age)) % RING_SLOTS;
            expected_q.push_back(record_to_rsp(KIND_READ, 1'b1, hist_ring[slot]));
         end else begin
            expected_q.push_back(record_to_rsp(KIND_READ, 1'b0, '0));
         end
         return;
      end
      if (!hist_started) begin
         hist_started     = 1'b1;
         hist_open_bucket = item.bucket_number;
      end else if (item.bucket_number != hist_open_bucket) begin
         expected_q.push_back(close_open_bucket());
         hist_open_bucket = item.bucket_number;
      end
      if (item.ph_present && ph_n < MAX_SAMPLES) begin
         ph_total += longint'(item.ph_hundredths);
         ph_n++;
      end
      if (item.orp_present && orp_n < MAX_SAMPLES) begin
         orp_total += longint'(signed'(item.orp_millivolts));
         orp_n++;
      end
      if (item.temp_present && temp_n < MAX_SAMPLES) begin
         temp_total += longint'(signed'(item.temp_tenths));
         temp_n++;
      end
   endfunction

   // ---------------------------------------------------------------- items

   function automatic req_type make_noise();
      logic [95:0] bits;
      bits = {$urandom, $urandom, $urandom};
      return bits[$bits(req_type)-1:0];
   endfunction

   function automatic req_type make_read(input logic [AGE_W-1:0] age);
      req_type item;
      item        = make_noise();
      item.opcode = OP_READ;
      item.age    = age;
      return item;
   endfunction

   function automatic req_type make_sample(input logic [31:0] bucket,
                                           input logic ph_on, input int ph,
                                           input logic orp_on, input int orp,
                                           input logic temp_on, input int temp);
      req_type item;
      item                = make_noise();
      item.opcode         = OP_SAMPLE;
      item.bucket_number  = bucket;
      item.ph_present     = ph_on;
      item.ph_hundredths  = ph[PH_W-1:0];
      item.orp_present    = orp_on;
      item.orp_millivolts = orp[MV_W-1:0];
      item.temp_present   = temp_on;
      item.temp_tenths    = temp[TEMP_W-1:0];
      return item;
   endfunction

   // mostly in the physical range, sometimes anywhere in the field
   function automatic int rand_ph();
      return ($urandom_range(7) == 0) ? int'($urandom_range(2047))
                                      : int'($urandom_range(1400));
   endfunction

   function automatic int rand_orp();
      return ($urandom_range(7) == 0) ? int'($urandom_range(4095)) - 2048
                                      : int'($urandom_range(4000)) - 2000;
   endfunction

   function automatic int rand_temp();
      return ($urandom_range(7) == 0) ? int'($urandom_range(4095)) - 2048
                                      : int'($urandom_range(1650)) - 400;
   endfunction

   function automatic req_type random_sample(input logic [31:0] bucket);
      return make_sample(bucket, $urandom_range(3) != 0, rand_ph(),
                         $urandom_range(3) != 0, rand_orp(),
                         $urandom_range(3) != 0, rand_temp());
   endfunction

   function automatic logic [AGE_W-1:0] pick_age();
      int top;
      top = (hist_filled > 0) ? hist_filled - 1 : 0;
      if ($urandom_range(1) == 0)
         return 8'($urandom_range(255));
      return 8'($urandom_range(top));
   endfunction

   // ---------------------------------------------------------------- channels

   task automatic send_item(input req_type item);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      predict_item(item);
   endtask

   always @(posedge clock) begin
      if (hold_orders != hold_taken) begin
         hold_taken <= hold_orders;
         hold_left  <= HOLD_CYCLES;
         rsp_stall  <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   function automatic void compare_field(input string field, input logic [31:0] want,
                                         input logic [31:0] got);
      if (got !== want) begin
         $display("%0t %s mismatch: expected %0h actual %0h", $time, field, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            $display("%0t unexpected transfer: expected none actual %h", $time, rsp_data);
            mismatches++;
         end else begin
            want = expected_q.pop_front();
            compare_field("kind", 32'(want.kind), 32'(rsp_data.kind));
            compare_field("slot_filled", 32'(want.slot_filled), 32'(rsp_data.slot_filled));
            compare_field("ph_avg_present", 32'(want.ph_avg_present),
                          32'(rsp_data.ph_avg_present));
            compare_field("ph_avg", 32'(want.ph_avg), 32'(rsp_data.ph_avg));
            compare_field("orp_avg_present", 32'(want.orp_avg_present),
                          32'(rsp_data.orp_avg_present));
            compare_field("orp_avg", 32'(want.orp_avg), 32'(rsp_data.orp_avg));
            compare_field("temp_avg_present", 32'(want.temp_avg_present),
                          32'(rsp_data.temp_avg_present));
            compare_field("temp_avg", 32'(want.temp_avg), 32'(rsp_data.temp_avg));
         end
      end
   end

   // ---------------------------------------------------------------- tests

   task automatic test_corner_cases();
      // reads of an empty history
      send_item(make_read(8'd0));
      send_item(make_read(8'd255));
      // first sample opens bucket zero, field extremes
      send_item(make_sample(32'd0, 1'b1, 0, 1'b1, -2048, 1'b1, 2047));
      send_item(make_sample(32'd0, 1'b1, 2047, 1'b1, 2047, 1'b1, -2048));
      // jump to the top bucket, rounding ties
      send_item(make_sample(32'hFFFF_FFFF, 1'b1, 1, 1'b1, -5, 1'b1, 2));
      send_item(make_sample(32'hFFFF_FFFF, 1'b1, 2, 1'b1, -6, 1'b1, 3));
      // wrap back to zero with no readings
      send_item(make_sample(32'd0, 1'b0, 0, 1'b0, 0, 1'b0, 0));
      // empty bucket closes
      send_item(make_sample(32'd7, 1'b1, 1400, 1'b1, 2000, 1'b1, 1250));
      send_item(make_sample(32'd7, 1'b1, 0, 1'b1, -2000, 1'b1, -400));
      send_item(make_sample(32'd7, 1'b1, 3, 1'b0, 0, 1'b0, 0));
      send_item(make_sample(32'd8, 1'b1, 1, 1'b1, -1, 1'b1, -3));
      send_item(make_sample(32'd8, 1'b1, 2, 1'b1, -2, 1'b0, 0));
      send_item(make_sample(32'd9, 1'b0, 0, 1'b0, 0, 1'b1, 5));
      send_item(make_sample(32'd10, 1'b0, 0, 1'b1, 7, 1'b0, 0));
      for (int age = 0; age < 8; age++)
         send_item(make_read(8'(age)));
      send_item(make_read(8'd255));
   endtask

   task automatic test_random_traffic(input int n_items);
      logic [31:0] bucket;
      int          run_left;
      bucket   = hist_open_bucket;
      run_left = 0;
      for (int i = 0; i < n_items; i++) begin
         case ($urandom_range(19))
            0, 1, 2, 3: send_item(make_read(pick_age()));
            4:          send_item(make_noise());
            default: begin
               if (run_left == 0) begin
                  run_left = $urandom_range(5, 1);
                  case ($urandom_range(7))
                     0:       bucket = $urandom;
                     1:       bucket = bucket + $urandom_range(50, 2);
                     default: bucket = bucket + 32'd1;
                  endcase
               end
               send_item(random_sample(bucket));
               run_left--;
            end
         endcase
      end
   endtask

   task automatic test_ring_wrap(input int n_closes);
      logic [31:0] bucket;
      bucket = hist_open_bucket;
      for (int i = 0; i < n_closes; i++) begin
         bucket = bucket + 32'd1;
         send_item(random_sample(bucket));
         if ($urandom_range(7) == 0)
            send_item(make_read(pick_age()));
      end
      send_item(make_sample(bucket + 32'd1, 1'b0, 0, 1'b0, 0, 1'b0, 0));
      send_item(make_read(8'd255));
      send_item(make_read(8'd254));
      send_item(make_read(8'd0));
   endtask

   task automatic test_backpressure();
      logic [31:0] bucket;
      bucket = hist_open_bucket;
      hold_orders <= hold_orders + 1;
      for (int i = 0; i < 16; i++) begin
         if (i % 3 == 2) begin
            send_item(make_read(pick_age()));
         end else begin
            bucket = bucket + 32'd1;
            send_item(random_sample(bucket));
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      req_idle_pct = 8;
      rsp_idle_pct = 72;
      test_corner_cases();
      test_random_traffic(80);

      req_idle_pct = 72;
      rsp_idle_pct = 8;
      test_ring_wrap(256);

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      test_random_traffic(60);
      test_backpressure();

      req_valid <= 1'b0;
      while (expected_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0)
         $display("** bucketed_average_history_core: PASSED **");
      else
         $display("** bucketed_average_history_core: FAILED **");
      $finish;
   end

endmodule
